>>> hw/rtl/mmit_pkg.sv
// Shared types, constants and the expiry function of the interval timer.
`default_nettype none

package mmit_pkg;

    // Item kinds carried in the func field.
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } t_func;

    // Window layout: timer words start at this byte and the window ends at the limit.
    localparam logic [5:0] WIN_TIMER_BASE = 6'h10;
    localparam logic [5:0] WIN_SIZE       = 6'h20;
    // Largest number of bytes one access can move.
    localparam logic [3:0] MAX_BYTES      = 4'd8;

    // One input word, unpacked.
    typedef struct packed {
        t_func       func;
        logic [4:0]  byte_addr;
        logic [3:0]  byte_count;
        logic [63:0] write_data;
    } t_item;

    // One result word.
    typedef struct packed {
        logic [63:0] read_data;
        logic        irq_pulse;
    } t_result;

    // Timer state.
    typedef struct packed {
        logic [31:0] now;
        logic [31:0] run;
        logic [31:0] interval;
        logic [31:0] start;
        logic [31:0] duration;
    } t_timer_state;

    // Outcome of one expiry check.
    typedef struct packed {
        logic         fire;
        t_timer_state st;
    } t_expiry;

    // A running timer (run nonzero) expires once now minus start (mod 2^32) reaches the duration.
    function automatic t_expiry check_expiry(input t_timer_state s);
        t_expiry     r;
        logic [31:0] elapsed;
        r       = '{fire: 1'b0, st: s};
        elapsed = s.now - s.start;
        if (s.run != 32'd0 && elapsed >= s.duration) begin
            r.fire        = 1'b1;
            r.st.start    = s.start + s.duration;
            r.st.duration = s.interval;
            if (s.interval == 32'd0) begin
                r.st.run = 32'd0;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mmit_exec.sv
// Next-state and result logic for one timer word: tick, byte read or byte write.
`default_nettype none

module mmit_exec (
    input  mmit_pkg::t_item        i_item,
    input  mmit_pkg::t_timer_state i_state,
    output mmit_pkg::t_timer_state o_state,
    output mmit_pkg::t_result      o_result
);
    import mmit_pkg::*;

    logic [3:0]   cnt;
    logic [127:0] win;
    logic [127:0] new_win;
    logic [15:0]  wen;
    logic [3:0]   touched;
    logic [63:0]  rd_all;
    logic [5:0]   rd_addr;
    logic [3:0]   rd_off;
    logic [2:0]   rd_pos;
    logic [6:0]   wr_dist;
    logic [2:0]   wr_pos;
    t_timer_state ws;
    t_timer_state pre;
    logic         do_check;
    t_expiry      exp_res;

    // Saturate the byte count and view the timer words as one big-endian window.
    always_comb begin
        cnt = (i_item.byte_count > MAX_BYTES) ? MAX_BYTES : i_item.byte_count;
        win = {i_state.run, i_state.interval, i_state.start, i_state.duration};
    end

    // Read path: byte i of the access lands in position cnt-1-i of the result.
    always_comb begin
        rd_all  = '0;
        rd_addr = '0;
        rd_off  = '0;
        rd_pos  = '0;
        for (int i = 0; i < 8; i++) begin
            rd_addr = 6'(i_item.byte_addr) + 6'(i);
            rd_off  = rd_addr[3:0];
            rd_pos  = 3'(cnt - 4'(i) - 4'd1);
            if (4'(i) < cnt && rd_addr >= WIN_TIMER_BASE && rd_addr < WIN_SIZE) begin
                rd_all[{rd_pos, 3'b000} +: 8] = win[{~rd_off, 3'b000} +: 8];
            end
        end
    end

    // Write path: merge the written bytes into the window, one check per timer byte.
    always_comb begin
        new_win = win;
        wen     = '0;
        wr_dist = '0;
        wr_pos  = '0;
        for (int j = 0; j < 16; j++) begin
            wr_dist = 7'(j) + 7'(WIN_TIMER_BASE) - 7'(i_item.byte_addr);
            wr_pos  = 3'(cnt - wr_dist[3:0] - 4'd1);
            if (wr_dist < 7'(cnt)) begin
                wen[j] = 1'b1;
                new_win[8*(15-j) +: 8] = i_item.write_data[{wr_pos, 3'b000} +: 8];
            end
        end
        touched = {|wen[15:12], |wen[11:8], |wen[7:4], |wen[3:0]};
        ws      = i_state;
        {ws.run, ws.interval, ws.start, ws.duration} = new_win;
    end

    // Choose the state that the expiry check sees, then run one check.
    always_comb begin
        pre      = i_state;
        do_check = 1'b0;
        case (i_item.func)
            FUNC_TICK: begin
                pre.now  = i_state.now + 32'd1;
                do_check = 1'b1;
            end
            FUNC_WRITE: begin
                pre = ws;
                if (touched == 4'b0000) begin
                    pre = i_state;
                end else if (touched[0] && ws.run == 32'd0) begin
                    // Stopped: written words are kept, nothing else happens.
                    pre = ws;
                end else if (touched[2] || touched[3]) begin
                    pre.run  = 32'd1;
                    do_check = 1'b1;
                end else if (touched[0]) begin
                    pre.start    = i_state.now;
                    pre.duration = ws.run;
                    do_check     = 1'b1;
                end
            end
            default: begin
                pre = i_state;
            end
        endcase
        exp_res = check_expiry(pre);
    end

    // Outputs: state after the item and the result word.
    always_comb begin
        o_state            = do_check ? exp_res.st : pre;
        o_result.irq_pulse = do_check & exp_res.fire;
        o_result.read_data = (i_item.func == FUNC_READ) ? rd_all : 64'd0;
    end

endmodule

`default_nettype wire

>>> hw/rtl/memory_mapped_ms_interval_timer.sv
// Top level of the millisecond interval timer with its 32-byte register window.
//
// Each input word is a 1 ms tick, a byte read or a byte write of up to eight
// bytes; every word yields exactly one result word. A word is captured in an
// input register, worked through the window, write-merge and expiry logic
// combinationally, and its result lands in an output register, so the block
// takes one word per cycle. A result is offered on the master side after its
// word has passed the input register and then the output register. Throughput
// falls below one word per cycle only while the output register is held by a
// stalled consumer; the input register then fills and the slave side
// deasserts tready. The first 16 bytes of the window read as zero and ignore
// writes.
`default_nettype none

module memory_mapped_ms_interval_timer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] func, [6:2] byte_addr, [10:7] byte_count, [74:11] write_data, [79:75] zero
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [63:0] read_data, [64] irq_pulse, [71:65] zero
    output logic [71:0]      m_axis_tdata
);
    import mmit_pkg::*;

    logic         r_in_valid;
    t_item        r_in;
    t_item        n_in;
    logic         r_out_valid;
    t_result      r_out;
    t_result      n_result;
    t_timer_state r_state;
    t_timer_state n_state;
    logic         s_accept;
    logic         advance;

    // Handshake: the input register drains whenever the output register can take a result.
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign advance       = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.irq_pulse, r_out.read_data};

    // Unpack the incoming word.
    always_comb begin
        n_in.func       = t_func'(s_axis_tdata[1:0]);
        n_in.byte_addr  = s_axis_tdata[6:2];
        n_in.byte_count = s_axis_tdata[10:7];
        n_in.write_data = s_axis_tdata[74:11];
    end

    mmit_exec u_exec (
        .i_item   (r_in),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Control state and timer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in <= n_in;
        end
        if (advance) begin
            r_out <= n_result;
        end
    end

    // A tick advances the millisecond counter by exactly one.
    a_tick_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.func == FUNC_TICK |=> r_state.now == $past(r_state.now) + 32'd1)
        else $error("tick did not advance the millisecond counter");

    // A read leaves the timer words untouched and raises no interrupt.
    a_read_no_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.func == FUNC_READ |=>
            r_state == $past(r_state) && !r_out.irq_pulse)
        else $error("read changed timer state or raised an interrupt");

    // A stopped timer cannot expire on a tick.
    a_stopped_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.func == FUNC_TICK && r_state.run == 32'd0 |=> !r_out.irq_pulse)
        else $error("stopped timer expired");

    // The input register only drains into a free or draining output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !advance)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
